FILE: sv/connection_flood_limiter_macros.svh
// Assertion macros shared by the connection flood limiter RTL.
// Each macro needs clk_i and rst_ni to be in scope where it is used.
`ifndef CONNECTION_FLOOD_LIMITER_MACROS_SVH
`define CONNECTION_FLOOD_LIMITER_MACROS_SVH

// The property must hold at every clock edge outside reset.
`define CFL_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("connection_flood_limiter: assertion failed");

// The condition must never be true outside reset.
`define CFL_ASSERT_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error("connection_flood_limiter: forbidden condition seen");

`endif

FILE: sv/cfl_pkg.sv
// Package for the connection flood limiter: sizes, payload and control types,
// register indexes and small ring helper functions. No dependencies.
`timescale 1ns / 1ps
package cfl_pkg;

  localparam int TABLE_ENTRIES     = 64;
  localparam int JOINS_PER_ENTRY   = 16;
  localparam int SWEEP_INTERVAL_MS = 1000;

  localparam int TIME_W     = 48;
  localparam int IP_W       = 32;
  localparam int MAXC_W     = 4;
  localparam int PERIOD_W   = 32;
  localparam int LIVE_W     = 7;
  localparam int ENT_W      = $clog2(TABLE_ENTRIES);
  localparam int LIVE_CNT_W = $clog2(TABLE_ENTRIES + 1);
  localparam int HEAD_W     = $clog2(JOINS_PER_ENTRY);
  localparam int CNT_W      = $clog2(JOINS_PER_ENTRY + 1);
  localparam int SUM_W      = CNT_W + 1;
  localparam int CMP_W      = (CNT_W > MAXC_W) ? CNT_W : MAXC_W;
  localparam int RING_DEPTH = TABLE_ENTRIES * JOINS_PER_ENTRY;
  localparam int RING_AW    = $clog2(RING_DEPTH);
  localparam int REQ_Q_DEPTH = 2;
  localparam int REQ_Q_PW   = $clog2(REQ_Q_DEPTH);
  localparam int REQ_Q_CW   = $clog2(REQ_Q_DEPTH + 1);

  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_CONNECTIONS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_PERIOD   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BAN_LENGTH      = 2'd2;

  localparam logic REQ_CONNECT = 1'b0;
  localparam logic REQ_CHECK   = 1'b1;

  typedef struct packed {
    logic              req_type;
    logic [IP_W-1:0]   ip_address;
    logic [TIME_W-1:0] now_ms;
  } req_t;

  typedef struct packed {
    logic              flooding;
    logic [LIVE_W-1:0] live_entries;
    logic              table_full;
  } res_t;

  typedef struct packed {
    logic [MAXC_W-1:0]   max_connections;
    logic [PERIOD_W-1:0] sample_period;
    logic [PERIOD_W-1:0] ban_length;
  } cfg_t;

  // Per-address record held in the entry memory.
  typedef struct packed {
    logic [IP_W-1:0]   ip_address;
    logic [TIME_W-1:0] ban_end;
    logic [HEAD_W-1:0] head;
    logic [CNT_W-1:0]  count;
  } meta_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SW_RD,
    ST_SW_META,
    ST_SW_RING,
    ST_SW_DONE,
    ST_LK_RD,
    ST_LK_CHK,
    ST_ALLOC,
    ST_ACT,
    ST_OUT
  } state_e;

  function automatic logic [HEAD_W-1:0] head_inc(logic [HEAD_W-1:0] h);
    return (h == HEAD_W'(JOINS_PER_ENTRY - 1)) ? '0 : h + 1'b1;
  endfunction

  function automatic logic [HEAD_W-1:0] slot_wrap(logic [HEAD_W-1:0] h,
                                                  logic [CNT_W-1:0] c);
    logic [SUM_W-1:0] sum;
    sum = SUM_W'(h) + SUM_W'(c);
    if (sum >= SUM_W'(JOINS_PER_ENTRY)) begin
      sum = sum - SUM_W'(JOINS_PER_ENTRY);
    end
    return HEAD_W'(sum);
  endfunction

  function automatic logic [RING_AW-1:0] ring_addr(logic [ENT_W-1:0] e,
                                                   logic [HEAD_W-1:0] s);
    return RING_AW'(RING_AW'(e) * RING_AW'(JOINS_PER_ENTRY)) + RING_AW'(s);
  endfunction

endpackage

FILE: sv/cfl_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`timescale 1ns / 1ps
module cfl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: sv/cfl_front.sv
// Request front end: a short queue that takes request beats and hands them
// to the engine one at a time. Depends on cfl_pkg.
`timescale 1ns / 1ps
module cfl_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push,
  input  cfl_pkg::req_t req_i,
  output logic          full,
  input  logic          deq_i,
  output logic          req_valid_o,
  output cfl_pkg::req_t req_o
);
  import cfl_pkg::*;

  req_t                slot_q [REQ_Q_DEPTH];
  logic [REQ_Q_PW-1:0] wr_ptr_q, wr_ptr_d;
  logic [REQ_Q_PW-1:0] rd_ptr_q, rd_ptr_d;
  logic [REQ_Q_CW-1:0] fill_q, fill_d;
  logic                do_push, do_pop;

  assign full        = (fill_q == REQ_Q_CW'(REQ_Q_DEPTH));
  assign req_valid_o = (fill_q != '0);
  assign req_o       = slot_q[rd_ptr_q];
  assign do_push     = push && !full;
  assign do_pop      = deq_i && req_valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    fill_d   = fill_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == REQ_Q_PW'(REQ_Q_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == REQ_Q_PW'(REQ_Q_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      fill_d = fill_q + 1'b1;
    end else if (do_pop && !do_push) begin
      fill_d = fill_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= req_i;
    end
  end

endmodule

FILE: sv/cfl_back.sv
// Limiter engine: sweep, table lookup, ban and join recording, result register.
// Depends on cfl_pkg, cfl_ram and connection_flood_limiter_macros.svh.
`timescale 1ns / 1ps
module cfl_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  cfl_pkg::cfg_t cfg_i,
  input  logic          req_valid_i,
  input  cfl_pkg::req_t req_i,
  output logic          deq_o,
  input  logic          pop,
  output logic          empty,
  output cfl_pkg::res_t res_o
);
  import cfl_pkg::*;

  state_e                  state_q, state_d;
  logic [ENT_W-1:0]        idx_q, idx_d;
  logic [ENT_W-1:0]        ent_q, ent_d;
  logic [ENT_W-1:0]        free_q, free_d;
  logic                    free_vld_q, free_vld_d;
  logic                    hit_q, hit_d;
  req_t                    req_q, req_d;
  meta_t                   meta_q, meta_d;
  logic [TABLE_ENTRIES-1:0] valid_q, valid_d;
  logic [LIVE_CNT_W-1:0]   live_q, live_d;
  logic [TIME_W-1:0]       last_sweep_q, last_sweep_d;
  logic [TIME_W-1:0]       win_edge_q, win_edge_d;
  logic                    edge_ok_q, edge_ok_d;
  res_t                    pend_q, pend_d;
  res_t                    res_q, res_d;
  logic                    res_valid_q, res_valid_d;

  logic                    meta_we;
  logic [ENT_W-1:0]        meta_waddr, meta_raddr;
  meta_t                   meta_wdata, meta_rdata;
  logic                    ring_we;
  logic [RING_AW-1:0]      ring_waddr, ring_raddr;
  logic [TIME_W-1:0]       ring_rdata;

  meta_t                   act_meta;
  logic [TIME_W:0]         ban_sum;
  logic                    sweep_due;
  logic                    idx_last;

  cfl_ram #(
    .WIDTH($bits(meta_t)),
    .DEPTH(TABLE_ENTRIES)
  ) u_meta_ram (
    .clk_i  (clk_i),
    .we_i   (meta_we),
    .waddr_i(meta_waddr),
    .wdata_i(meta_wdata),
    .raddr_i(meta_raddr),
    .rdata_o(meta_rdata)
  );

  cfl_ram #(
    .WIDTH(TIME_W),
    .DEPTH(RING_DEPTH)
  ) u_ring_ram (
    .clk_i  (clk_i),
    .we_i   (ring_we),
    .waddr_i(ring_waddr),
    .wdata_i(req_q.now_ms),
    .raddr_i(ring_raddr),
    .rdata_o(ring_rdata)
  );

  assign sweep_due = (req_i.now_ms >= last_sweep_q) &&
                     ((req_i.now_ms - last_sweep_q) >= TIME_W'(SWEEP_INTERVAL_MS));
  assign idx_last  = (idx_q == ENT_W'(TABLE_ENTRIES - 1));
  assign ban_sum   = {1'b0, req_q.now_ms} + (TIME_W + 1)'(cfg_i.ban_length);
  assign empty     = !res_valid_q;
  assign res_o     = res_q;

  always_comb begin
    state_d      = state_q;
    idx_d        = idx_q;
    ent_d        = ent_q;
    free_d       = free_q;
    free_vld_d   = free_vld_q;
    hit_d        = hit_q;
    req_d        = req_q;
    meta_d       = meta_q;
    valid_d      = valid_q;
    live_d       = live_q;
    last_sweep_d = last_sweep_q;
    win_edge_d   = win_edge_q;
    edge_ok_d    = edge_ok_q;
    pend_d       = pend_q;
    res_d        = res_q;
    res_valid_d  = res_valid_q;
    deq_o        = 1'b0;
    meta_we      = 1'b0;
    meta_waddr   = ent_q;
    meta_wdata   = meta_q;
    meta_raddr   = idx_q;
    ring_we      = 1'b0;
    ring_waddr   = ring_addr(ent_q, meta_q.head);
    ring_raddr   = ring_addr(idx_q, meta_q.head);
    act_meta     = meta_q;

    if (pop && res_valid_q) begin
      res_valid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (req_valid_i) begin
          deq_o      = 1'b1;
          req_d      = req_i;
          idx_d      = '0;
          free_vld_d = 1'b0;
          win_edge_d = req_i.now_ms - TIME_W'(cfg_i.sample_period);
          edge_ok_d  = req_i.now_ms >= TIME_W'(cfg_i.sample_period);
          if (sweep_due) begin
            last_sweep_d = req_i.now_ms;
            state_d      = ST_SW_RD;
          end else begin
            state_d = ST_LK_RD;
          end
        end
      end
      ST_SW_RD: begin
        if (valid_q[idx_q]) begin
          state_d = ST_SW_META;
        end else if (idx_last) begin
          idx_d   = '0;
          state_d = ST_LK_RD;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end
      ST_SW_META: begin
        meta_d = meta_rdata;
        // Banned entries keep their join times untouched.
        if (req_q.now_ms < meta_rdata.ban_end) begin
          if (idx_last) begin
            idx_d   = '0;
            state_d = ST_LK_RD;
          end else begin
            idx_d   = idx_q + 1'b1;
            state_d = ST_SW_RD;
          end
        end else if (edge_ok_q && (meta_rdata.count != '0)) begin
          ring_raddr = ring_addr(idx_q, meta_rdata.head);
          state_d    = ST_SW_RING;
        end else begin
          state_d = ST_SW_DONE;
        end
      end
      ST_SW_RING: begin
        if (ring_rdata <= win_edge_q) begin
          meta_d.head  = head_inc(meta_q.head);
          meta_d.count = meta_q.count - 1'b1;
          ring_raddr   = ring_addr(idx_q, head_inc(meta_q.head));
          if (meta_q.count == CNT_W'(1)) begin
            state_d = ST_SW_DONE;
          end
        end else begin
          state_d = ST_SW_DONE;
        end
      end
      ST_SW_DONE: begin
        if (meta_q.count == '0) begin
          valid_d[idx_q] = 1'b0;
          live_d         = live_q - 1'b1;
        end else begin
          meta_we    = 1'b1;
          meta_waddr = idx_q;
        end
        if (idx_last) begin
          idx_d   = '0;
          state_d = ST_LK_RD;
        end else begin
          idx_d   = idx_q + 1'b1;
          state_d = ST_SW_RD;
        end
      end
      ST_LK_RD: begin
        if (valid_q[idx_q]) begin
          state_d = ST_LK_CHK;
        end else begin
          if (!free_vld_q) begin
            free_d     = idx_q;
            free_vld_d = 1'b1;
          end
          if (idx_last) begin
            state_d = ST_ALLOC;
          end else begin
            idx_d = idx_q + 1'b1;
          end
        end
      end
      ST_LK_CHK: begin
        if (meta_rdata.ip_address == req_q.ip_address) begin
          hit_d   = 1'b1;
          ent_d   = idx_q;
          meta_d  = meta_rdata;
          state_d = ST_ACT;
        end else if (idx_last) begin
          state_d = ST_ALLOC;
        end else begin
          idx_d   = idx_q + 1'b1;
          state_d = ST_LK_RD;
        end
      end
      ST_ALLOC: begin
        hit_d = free_vld_q;
        if (free_vld_q) begin
          ent_d             = free_q;
          meta_d.ip_address = req_q.ip_address;
          meta_d.ban_end    = '0;
          meta_d.head       = '0;
          meta_d.count      = '0;
          valid_d[free_q]   = 1'b1;
          live_d            = live_q + 1'b1;
        end
        state_d = ST_ACT;
      end
      ST_ACT: begin
        pend_d.flooding     = 1'b0;
        pend_d.table_full   = 1'b0;
        pend_d.live_entries = LIVE_W'(live_q);
        if (!hit_q) begin
          pend_d.table_full = 1'b1;
        end else begin
          // The record is always written back so a fresh allocation lands.
          meta_we = 1'b1;
          if (req_q.now_ms < meta_q.ban_end) begin
            pend_d.flooding = 1'b1;
          end else if (CMP_W'(meta_q.count) > CMP_W'(cfg_i.max_connections)) begin
            act_meta.ban_end = ban_sum[TIME_W] ? '1 : ban_sum[TIME_W-1:0];
            pend_d.flooding  = 1'b1;
          end else if (req_q.req_type == REQ_CONNECT) begin
            // A full ring drops its oldest time to make room.
            if (meta_q.count >= CNT_W'(JOINS_PER_ENTRY)) begin
              act_meta.head  = head_inc(meta_q.head);
              act_meta.count = meta_q.count - 1'b1;
            end
            ring_we        = 1'b1;
            ring_waddr     = ring_addr(ent_q, slot_wrap(act_meta.head, act_meta.count));
            act_meta.count = act_meta.count + 1'b1;
          end
          meta_wdata = act_meta;
        end
        state_d = ST_OUT;
      end
      ST_OUT: begin
        if (!res_valid_q || pop) begin
          res_d       = pend_q;
          res_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      valid_q      <= '0;
      live_q       <= '0;
      last_sweep_q <= '0;
      res_valid_q  <= 1'b0;
      hit_q        <= 1'b0;
      free_vld_q   <= 1'b0;
      idx_q        <= '0;
    end else begin
      state_q      <= state_d;
      valid_q      <= valid_d;
      live_q       <= live_d;
      last_sweep_q <= last_sweep_d;
      res_valid_q  <= res_valid_d;
      hit_q        <= hit_d;
      free_vld_q   <= free_vld_d;
      idx_q        <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ent_q      <= ent_d;
    free_q     <= free_d;
    req_q      <= req_d;
    meta_q     <= meta_d;
    win_edge_q <= win_edge_d;
    edge_ok_q  <= edge_ok_d;
    pend_q     <= pend_d;
    res_q      <= res_d;
  end

`include "connection_flood_limiter_macros.svh"

  `CFL_ASSERT(a_live_bound, live_q <= LIVE_CNT_W'(TABLE_ENTRIES))
  `CFL_ASSERT(a_live_matches_valid, live_q == LIVE_CNT_W'($countones(valid_q)))
  `CFL_ASSERT(a_deq_only_idle, deq_o |-> ((state_q == ST_IDLE) && req_valid_i))
  `CFL_ASSERT(a_act_then_out, (state_q == ST_ACT) |=> (state_q == ST_OUT))
  `CFL_ASSERT_NEVER(a_ring_overfill, (state_q == ST_ACT) && hit_q && (meta_q.count > CNT_W'(JOINS_PER_ENTRY)))

endmodule

FILE: sv/connection_flood_limiter.sv
// Connection flood limiter. Requests enter a two-beat queue and are served one
// at a time by the engine; each gives exactly one result beat. A request leaves
// the queue; the engine then walks the table entries, searching held entries
// through the entry memory (the search stops at the matching address),
// allocates a free entry to a new address, applies the verdict and loads the
// result register. When a sweep is due (once per 1000 ms of request time), the
// engine first walks all 64 entries: banned entries are left untouched, and
// each other held entry has its ring of up to 16 join times trimmed of those
// that fall outside the sample period; an entry left with none is freed. A
// result beat that is not popped holds the engine until it is. Depends on
// cfl_pkg, cfl_front and cfl_back.
`timescale 1ns / 1ps
module connection_flood_limiter (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             push,
  output logic                             full,
  input  cfl_pkg::req_t                    req_i,
  output logic                             empty,
  input  logic                             pop,
  output cfl_pkg::res_t                    res_o,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [cfl_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [cfl_pkg::PERIOD_W-1:0]     cfg_data_i
);
  import cfl_pkg::*;

  cfg_t cfg_q, cfg_d;
  logic req_valid;
  req_t req_head;
  logic deq;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_MAX_CONNECTIONS: cfg_d.max_connections = cfg_data_i[MAXC_W-1:0];
        CFG_SAMPLE_PERIOD:   cfg_d.sample_period   = cfg_data_i;
        CFG_BAN_LENGTH:      cfg_d.ban_length      = cfg_data_i;
        default:             cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.max_connections <= MAXC_W'(4);
      cfg_q.sample_period   <= PERIOD_W'(10000);
      cfg_q.ban_length      <= PERIOD_W'(30000);
    end else begin
      cfg_q <= cfg_d;
    end
  end

  cfl_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push       (push),
    .req_i      (req_i),
    .full       (full),
    .deq_i      (deq),
    .req_valid_o(req_valid),
    .req_o      (req_head)
  );

  cfl_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .req_valid_i(req_valid),
    .req_i      (req_head),
    .deq_o      (deq),
    .pop        (pop),
    .empty      (empty),
    .res_o      (res_o)
  );

endmodule
